FILE: rtl/core/delayed_message_timer_table_macros.svh
// Assertion helpers for the timer table RTL.
`ifndef DELAYED_MESSAGE_TIMER_TABLE_MACROS_SVH
`define DELAYED_MESSAGE_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define DMTT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define DMTT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dmtt_pkg.sv
package dmtt_pkg;

    // Fixed field widths of the request and result ports
    localparam int DELAY_W   = 16;
    localparam int MSG_W     = 8;
    localparam int CNT_OUT_W = 5;

    // Parameter defaults and limits
    localparam int SLOTS_DEF      = 16;
    localparam int SLOTS_MAX      = 64;
    localparam int COUNT_BITS_DEF = 16;
    localparam int ID_BITS_DEF    = 8;

    // Width of the running busy count carried along the chain
    localparam int CNT_W = $clog2(SLOTS_MAX + 1);

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_SCHED  = 2'd1,
        MODE_CANCEL = 2'd2,
        MODE_QUERY  = 2'd3
    } t_mode;

    // Packet handed from one cell to the next
    typedef struct packed {
        logic             tok;    // packet is live at this cell
        logic             want;   // schedule still looking for a free slot
        logic             found;  // a busy slot upstream holds the id
        logic [CNT_W-1:0] cnt;    // busy slots upstream, after this request
    } t_wave;

endpackage

FILE: rtl/core/dmtt_cell.sv
module dmtt_cell #(
    parameter int COUNT_BITS = dmtt_pkg::COUNT_BITS_DEF,
    parameter int ID_BITS    = dmtt_pkg::ID_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dmtt_pkg::t_mode       i_mode,
    input  logic [ID_BITS-1:0]    i_id,
    input  logic [COUNT_BITS-1:0] i_delay,
    input  logic                  i_core,
    input  dmtt_pkg::t_wave       i_wave,
    output dmtt_pkg::t_wave       o_wave,
    input  logic                  i_fire_clr,
    output logic                  o_fire,
    output logic [ID_BITS-1:0]    o_id,
    output logic                  o_core
);
    import dmtt_pkg::*;

    logic                  r_busy;
    logic                  r_fire;
    logic [COUNT_BITS-1:0] r_rem;
    logic [ID_BITS-1:0]    r_id;
    logic                  r_core;
    logic                  r_tok;
    logic                  r_want;
    logic                  r_found;
    logic [CNT_W-1:0]      r_cnt;

    logic n_busy;
    logic w_match;
    logic w_expire;
    logic w_claim;

    assign w_match  = r_busy && (r_id == i_id);
    assign w_expire = r_busy && (r_rem == COUNT_BITS'(1));
    assign w_claim  = i_wave.want && !r_busy;

    // Work out the slot's busy flag once the packet has passed
    always_comb begin
        n_busy = r_busy;
        if (i_wave.tok) begin
            unique case (i_mode)
                MODE_TICK:   n_busy = r_busy && !w_expire;
                MODE_SCHED:  n_busy = r_busy || i_wave.want;
                MODE_CANCEL: n_busy = r_busy && !w_match;
                MODE_QUERY:  n_busy = r_busy;
                default:     n_busy = r_busy;
            endcase
        end
    end

    // Hold slot control state and pass the packet on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fire <= 1'b0;
            r_tok  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_tok  <= i_wave.tok;
            if (i_wave.tok && (i_mode == MODE_TICK) && w_expire) begin
                r_fire <= 1'b1;
            end else if (i_fire_clr) begin
                r_fire <= 1'b0;
            end
        end
    end

    // Advance the packet payload and the slot contents
    always_ff @(posedge i_clk) begin
        r_want  <= i_wave.want && r_busy;
        r_found <= i_wave.found || w_match;
        r_cnt   <= i_wave.cnt + CNT_W'(n_busy);
        if (i_wave.tok) begin
            if ((i_mode == MODE_SCHED) && w_claim) begin
                r_rem  <= i_delay;
                r_id   <= i_id;
                r_core <= i_core;
            end else if ((i_mode == MODE_TICK) && r_busy) begin
                r_rem <= r_rem - COUNT_BITS'(1);
            end
        end
    end

    assign o_wave = '{tok: r_tok, want: r_want, found: r_found, cnt: r_cnt};
    assign o_fire = r_fire;
    assign o_id   = r_id;
    assign o_core = r_core;

endmodule

FILE: rtl/core/delayed_message_timer_table.sv
// One-shot delayed-message timer table. Each request (tick, schedule, cancel or
// query) is carried by a packet that walks the row of SLOTS slot cells, one cell
// per cycle; each cell acts on the request as the packet passes and adds its busy
// flag to the running count. Once the packet leaves the last cell, the request gives
// one result, or one per expired slot for a tick (up to SLOTS results for a tick that
// expires every slot); each result waits in the output register until it is taken.
// A new request is taken once the previous request's last result is in the output
// register; that result may still wait to be taken. Schedule delays of zero are
// raised to one tick and delays wider than the counter saturate. There is no
// clearing pass after reset: only the slot flags (busy, fire, token) are cleared.
module delayed_message_timer_table #(
    parameter int SLOTS      = dmtt_pkg::SLOTS_DEF,
    parameter int COUNT_BITS = dmtt_pkg::COUNT_BITS_DEF,
    parameter int ID_BITS    = dmtt_pkg::ID_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_mode,
    input  logic [dmtt_pkg::MSG_W-1:0]       i_msg_id,
    input  logic [dmtt_pkg::DELAY_W-1:0]     i_delay_ticks,
    input  logic                             i_target_core,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_fired,
    output logic [dmtt_pkg::MSG_W-1:0]       o_fired_id,
    output logic                             o_fired_core,
    output logic                             o_status,
    output logic                             o_found,
    output logic [dmtt_pkg::CNT_OUT_W-1:0]   o_pending_count,
    output logic                             o_last
);
    import dmtt_pkg::*;

    localparam int WB = (COUNT_BITS > DELAY_W) ? COUNT_BITS : DELAY_W;
    localparam logic [WB-1:0] CMAX = WB'({COUNT_BITS{1'b1}});

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAVE,
        ST_EMIT
    } t_state;

    t_state                r_state;
    t_mode                 r_mode;
    logic [ID_BITS-1:0]    r_id;
    logic [COUNT_BITS-1:0] r_delay;
    logic                  r_core;
    logic                  r_inj_tok;
    logic [CNT_W-1:0]      r_count;
    logic                  r_status;
    logic                  r_found;
    logic                  r_ovalid;
    logic                  r_fired;
    logic [MSG_W-1:0]      r_fired_id;
    logic                  r_fired_core;
    logic                  r_ostatus;
    logic                  r_ofound;
    logic [CNT_OUT_W-1:0]  r_ocount;
    logic                  r_last;

    t_wave                 w_wave [SLOTS+1];
    logic [SLOTS:0]        w_toks;
    logic [SLOTS-1:0]      w_fire;
    logic [SLOTS-1:0]      w_pick;
    logic [SLOTS-1:0]      w_rest;
    logic [SLOTS-1:0]      w_fire_clr;
    logic [ID_BITS-1:0]    w_cell_id [SLOTS];
    logic [SLOTS-1:0]      w_cell_core;
    logic [ID_BITS-1:0]    w_sel_id;
    logic                  w_sel_core;
    logic                  w_any;
    logic                  w_load;
    logic [WB-1:0]         w_delay_ext;
    logic [WB-1:0]         w_sat;

    // Raise a zero delay to one tick and clip to the counter range
    assign w_delay_ext = WB'(i_delay_ticks);
    always_comb begin
        w_sat = (w_delay_ext > CMAX) ? CMAX : w_delay_ext;
        if (w_sat == '0) begin
            w_sat = WB'(1);
        end
    end

    // Inject the request packet at the head of the row
    assign w_wave[0] = '{tok: r_inj_tok, want: (r_mode == MODE_SCHED), found: 1'b0,
                         cnt: '0};

    // Row of slot cells
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        dmtt_cell #(
            .COUNT_BITS(COUNT_BITS),
            .ID_BITS   (ID_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_mode    (r_mode),
            .i_id      (r_id),
            .i_delay   (r_delay),
            .i_core    (r_core),
            .i_wave    (w_wave[g]),
            .o_wave    (w_wave[g+1]),
            .i_fire_clr(w_fire_clr[g]),
            .o_fire    (w_fire[g]),
            .o_id      (w_cell_id[g]),
            .o_core    (w_cell_core[g])
        );
    end

    for (genvar t = 0; t <= SLOTS; t++) begin : g_tok
        assign w_toks[t] = w_wave[t].tok;
    end

    // Pick the lowest expired slot and the ones still left after it
    assign w_pick = w_fire & (~w_fire + SLOTS'(1));
    assign w_rest = w_fire & ~w_pick;
    assign w_any  = (r_mode == MODE_TICK) && (w_fire != '0);

    always_comb begin
        w_sel_id   = '0;
        w_sel_core = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (w_pick[i]) begin
                w_sel_id   = w_sel_id | w_cell_id[i];
                w_sel_core = w_sel_core | w_cell_core[i];
            end
        end
    end

    assign w_load     = (r_state == ST_EMIT) && (!r_ovalid || i_ready);
    assign w_fire_clr = (w_load && w_any) ? w_pick : '0;

    // Sequence the request and hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_inj_tok <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_inj_tok <= 1'b0;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_inj_tok <= 1'b1;
                        r_state   <= ST_WAVE;
                    end
                end
                ST_WAVE: begin
                    if (w_wave[SLOTS].tok) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_load && (!w_any || (w_rest == '0))) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Latch request fields, the chain's summary and result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_valid) begin
            r_mode  <= t_mode'(i_mode);
            r_id    <= ID_BITS'(i_msg_id);
            r_delay <= COUNT_BITS'(w_sat);
            r_core  <= i_target_core;
        end
        if ((r_state == ST_WAVE) && w_wave[SLOTS].tok) begin
            r_count  <= w_wave[SLOTS].cnt;
            r_status <= w_wave[SLOTS].want;
            r_found  <= w_wave[SLOTS].found;
        end
        if (w_load) begin
            r_fired      <= w_any;
            r_fired_id   <= MSG_W'(w_sel_id);
            r_fired_core <= w_sel_core;
            r_ostatus    <= (r_mode == MODE_SCHED) && r_status;
            r_ofound     <= (r_mode == MODE_QUERY) && r_found;
            r_ocount     <= CNT_OUT_W'(r_count);
            r_last       <= !w_any || (w_rest == '0);
        end
    end

    assign o_ready         = (r_state == ST_IDLE);
    assign o_valid         = r_ovalid;
    assign o_fired         = r_fired;
    assign o_fired_id      = r_fired_id;
    assign o_fired_core    = r_fired_core;
    assign o_status        = r_ostatus;
    assign o_found         = r_ofound;
    assign o_pending_count = r_ocount;
    assign o_last          = r_last;

`include "delayed_message_timer_table_macros.svh"

    `DMTT_ASSERT_IMP(a_one_packet, i_clk, i_rst_n, 1'b1, $onehot0(w_toks), "two packets in the row")
    `DMTT_ASSERT_IMP(a_accept_empty, i_clk, i_rst_n, i_valid && o_ready, w_toks == '0, "request taken while row busy")
    `DMTT_ASSERT_IMP(a_tail_in_wave, i_clk, i_rst_n, w_wave[SLOTS].tok, r_state == ST_WAVE, "packet left row outside walk")
    `DMTT_ASSERT_NXT(a_fire_drop, i_clk, i_rst_n, w_fire_clr != '0, (w_fire & $past(w_pick)) == '0, "delivered slot still flagged")

endmodule

FILE: bench/tb_delayed_message_timer_table.sv
`timescale 1ns / 100ps

module tb_delayed_message_timer_table;
    import dmtt_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int TABLE_SLOTS = 16;
    localparam int QUIET_TAIL  = 15;   // requests left when idling stops
    localparam int HOLD_AFTER  = 60;   // results taken before the long hold-off
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_WAIT  = 60;

    typedef struct {
        t_mode       mode;
        logic [7:0]  msg_id;
        logic [15:0] delay;
        logic        core;
    } timer_request_t;

    typedef struct {
        logic       fired;
        logic [7:0] fired_id;
        logic       fired_core;
        logic       status;
        logic       found;
        logic [4:0] pending;
        logic       last;
    } timer_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_mode = MODE_TICK;
    logic [7:0]  i_msg_id = '0;
    logic [15:0] i_delay_ticks = '0;
    logic        i_target_core = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_fired;
    logic [7:0]  o_fired_id;
    logic        o_fired_core;
    logic        o_status;
    logic        o_found;
    logic [4:0]  o_pending_count;
    logic        o_last;

    delayed_message_timer_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_msg_id        (i_msg_id),
        .i_delay_ticks   (i_delay_ticks),
        .i_target_core   (i_target_core),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_fired         (o_fired),
        .o_fired_id      (o_fired_id),
        .o_fired_core    (o_fired_core),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_pending_count (o_pending_count),
        .o_last          (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the slot table
    logic        slot_busy      [TABLE_SLOTS];
    logic [15:0] slot_remaining [TABLE_SLOTS];
    logic [7:0]  slot_message   [TABLE_SLOTS];
    logic        slot_core      [TABLE_SLOTS];

    timer_request_t queued_requests[$];
    timer_result_t  expected_results[$];
    timer_request_t offered_request;

    int error_count      = 0;
    int results_taken    = 0;
    int requests_taken   = 0;
    int schedules_seen   = 0;
    int refusals_seen    = 0;
    int ticks_seen       = 0;
    int deliveries_seen  = 0;
    int cancels_seen     = 0;
    int queries_seen     = 0;
    int query_hits       = 0;

    initial begin
        for (int s = 0; s < TABLE_SLOTS; s++) begin
            slot_busy[s]      = 1'b0;
            slot_remaining[s] = '0;
            slot_message[s]   = '0;
            slot_core[s]      = 1'b0;
        end
    end

    function automatic logic [4:0] busy_slots();
        logic [4:0] n;
        n = '0;
        for (int s = 0; s < TABLE_SLOTS; s++)
            n += slot_busy[s];
        return n;
    endfunction

    // Apply one request to the shadow table and queue the results it gives
    task automatic apply_to_table(input timer_request_t req);
        timer_result_t res;
        logic [7:0]    fire_id   [TABLE_SLOTS];
        logic          fire_core [TABLE_SLOTS];
        int            n_fire;
        logic [15:0]   delay;
        n_fire = 0;
        res = '{default: '0};
        res.last = 1'b1;
        case (req.mode)
            MODE_TICK: begin
                ticks_seen++;
                for (int s = 0; s < TABLE_SLOTS; s++) begin
                    if (slot_busy[s]) begin
                        slot_remaining[s] -= 16'd1;
                        if (slot_remaining[s] == '0) begin
                            fire_id[n_fire]   = slot_message[s];
                            fire_core[n_fire] = slot_core[s];
                            n_fire++;
                            slot_busy[s] = 1'b0;
                        end
                    end
                end
                res.pending = busy_slots();
                if (n_fire == 0) begin
                    expected_results.push_back(res);
                end
                for (int k = 0; k < n_fire; k++) begin
                    res.fired      = 1'b1;
                    res.fired_id   = fire_id[k];
                    res.fired_core = fire_core[k];
                    res.last       = (k == n_fire - 1);
                    expected_results.push_back(res);
                end
                deliveries_seen += n_fire;
            end
            MODE_SCHED: begin
                schedules_seen++;
                // A zero delay still waits one tick
                delay = (req.delay == '0) ? 16'd1 : req.delay;
                res.status = 1'b1;
                for (int s = 0; s < TABLE_SLOTS; s++) begin
                    if (!slot_busy[s] && res.status) begin
                        slot_busy[s]      = 1'b1;
                        slot_remaining[s] = delay;
                        slot_message[s]   = req.msg_id;
                        slot_core[s]      = req.core;
                        res.status        = 1'b0;
                    end
                end
                refusals_seen += res.status;
                res.pending = busy_slots();
                expected_results.push_back(res);
            end
            MODE_CANCEL: begin
                cancels_seen++;
                for (int s = 0; s < TABLE_SLOTS; s++)
                    if (slot_busy[s] && slot_message[s] == req.msg_id)
                        slot_busy[s] = 1'b0;
                res.pending = busy_slots();
                expected_results.push_back(res);
            end
            default: begin
                queries_seen++;
                for (int s = 0; s < TABLE_SLOTS; s++)
                    if (slot_busy[s] && slot_message[s] == req.msg_id)
                        res.found = 1'b1;
                query_hits += res.found;
                res.pending = busy_slots();
                expected_results.push_back(res);
            end
        endcase
    endtask

    task automatic add_request(input t_mode mode, input logic [7:0] msg_id,
                               input logic [15:0] delay, input logic core);
        timer_request_t req;
        req.mode   = mode;
        req.msg_id = msg_id;
        req.delay  = delay;
        req.core   = core;
        queued_requests.push_back(req);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Request driver: offer queued requests, with random gaps until the tail
    int send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                apply_to_table(offered_request);
                requests_taken++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (queued_requests.size() >= QUIET_TAIL &&
                             $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 6);
                    i_valid <= 1'b0;
                end else if (queued_requests.size() > 0) begin
                    offered_request = queued_requests.pop_front();
                    i_mode        <= offered_request.mode;
                    i_msg_id      <= offered_request.msg_id;
                    i_delay_ticks <= offered_request.delay;
                    i_target_core <= offered_request.core;
                    i_valid       <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result checker: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        timer_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            results_taken++;
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got fired %0b id %0d count %0d",
                         $time, o_fired, o_fired_id, o_pending_count);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("fired", want.fired, o_fired);
                check_field("fired_id", want.fired_id, o_fired_id);
                check_field("fired_core", want.fired_core, o_fired_core);
                check_field("status", want.status, o_status);
                check_field("found", want.found, o_found);
                check_field("pending_count", want.pending, o_pending_count);
                check_field("last", want.last, o_last);
            end
        end
    end

    // Result acceptor: random stalls, plus one long hold-off to back the table up
    int  sink_gap   = 0;
    int  hold_left  = 0;
    bit  hold_done  = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (!hold_done && results_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_ready <= 1'b0;
        end else if (queued_requests.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 6);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Build the request list, run reset, then wait for the table to drain
    initial begin
        int          pick;
        logic [7:0]  msg_id;
        logic [15:0] delay;

        // Empty table, zero and longest delays, both cores, edge ids
        add_request(MODE_TICK,   8'h00, 16'd7,     1'b0);
        add_request(MODE_SCHED,  8'h00, 16'd0,     1'b0);
        add_request(MODE_SCHED,  8'hFF, 16'd1,     1'b1);
        add_request(MODE_SCHED,  8'hAA, 16'hFFFF,  1'b1);
        add_request(MODE_SCHED,  8'hAA, 16'd2,     1'b0);
        add_request(MODE_QUERY,  8'hFF, 16'd0,     1'b0);
        add_request(MODE_TICK,   8'h00, 16'd0,     1'b0);
        // Cancel two slots at once, then miss
        add_request(MODE_CANCEL, 8'hAA, 16'd0,     1'b0);
        add_request(MODE_CANCEL, 8'h55, 16'd0,     1'b1);
        add_request(MODE_QUERY,  8'hAA, 16'd0,     1'b1);
        // Fill every slot, get refused, then expire all of them on one tick
        for (int k = 0; k < TABLE_SLOTS; k++)
            add_request(MODE_SCHED, 8'h10 + 8'(k % 4), 16'd1, 1'(k));
        add_request(MODE_SCHED,  8'h77, 16'd3,     1'b1);
        add_request(MODE_TICK,   8'h00, 16'd0,     1'b0);

        // Random mix: short delays and a small id pool so slots expire and match
        for (int n = 0; n < 72; n++) begin
            pick   = $urandom_range(0, 99);
            msg_id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
            delay  = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
            if (pick < 33)
                add_request(MODE_TICK, 8'($urandom), 16'($urandom), 1'($urandom));
            else if (pick < 78)
                add_request(MODE_SCHED, msg_id, delay, 1'($urandom));
            else if (pick < 90)
                add_request(MODE_CANCEL, msg_id, 16'($urandom), 1'($urandom));
            else
                add_request(MODE_QUERY, msg_id, 16'($urandom), 1'($urandom));
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_requests.size() > 0 || i_valid)
            @(posedge i_clk);
        while (expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d requests: %0d schedules (%0d refused), %0d ticks delivering %0d messages,",
                 requests_taken, schedules_seen, refusals_seen, ticks_seen, deliveries_seen);
        $display("%0d cancels and %0d queries (%0d hits); %0d results checked.",
                 cancels_seen, queries_seen, query_hits, results_taken);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding", expected_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: delayed_message_timer_table.f
+incdir+rtl/core
rtl/core/dmtt_pkg.sv
rtl/core/dmtt_cell.sv
rtl/core/delayed_message_timer_table.sv
bench/tb_delayed_message_timer_table.sv
